@@ src/rrs_pkg.sv @@
// shared types and constants of the round-robin scheduler
`default_nettype none

package rrs_pkg;

  localparam int IDX_W = 3;
  localparam int CNT_W = 8;
  localparam int PC_W  = 5;
  localparam int OP_W  = 2;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_DONE1   = 2'd1,
    CMD_DONE2   = 2'd2,
    CMD_SYSCALL = 2'd3
  } cmd_e;

  // controller to datapath
  typedef struct packed {
    logic capture;     // latch the input beat
    logic tick_start;  // preempt current task and arm the search
    logic sys_start;   // block caller, enqueue and arm the search
    logic search;      // test one candidate
    logic uses_upd;    // release fifo head and bump its count
    logic out_load;    // load the result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic tick_go;
    logic fifo_empty;
    logic sys_ok;
    logic found;
    logic last;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ src/rrs_ctrl.sv @@
// sequencing controller of the round-robin scheduler
`default_nettype none

module rrs_ctrl import rrs_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_HEAD   = 6'b000100,
    S_COUNT  = 6'b001000,
    S_SEARCH = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign load        = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.capture  = accept;
    cmd_o.out_load = load;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        case (stat_i.cmd)
          CMD_TICK: begin
            if (stat_i.tick_go) begin
              cmd_o.tick_start = 1'b1;
              state_d = S_SEARCH;
            end else begin
              state_d = S_DONE;
            end
          end
          CMD_DONE1, CMD_DONE2: begin
            // head read is in flight, data lands next cycle
            state_d = stat_i.fifo_empty ? S_DONE : S_HEAD;
          end
          CMD_SYSCALL: begin
            if (stat_i.sys_ok) begin
              cmd_o.sys_start = 1'b1;
              state_d = S_SEARCH;
            end else begin
              state_d = S_DONE;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_HEAD: begin
        state_d = S_COUNT;
      end
      S_COUNT: begin
        cmd_o.uses_upd = 1'b1;
        state_d = S_DONE;
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        if (stat_i.found || stat_i.last) state_d = S_DONE;
      end
      S_DONE: begin
        if (load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

@@ src/rrs_dp.sv @@
// datapath of the round-robin scheduler: task flags, device queues, counts
`default_nettype none

module rrs_dp import rrs_pkg::*; #(
  parameter int NUM_TASKS = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [1:0]       command_i,
  input  wire logic [IDX_W-1:0] task_index_i,
  input  wire logic             device_select_i,
  input  wire logic [OP_W-1:0]  operation_i,
  input  wire logic [PC_W-1:0]  program_counter_i,
  input  wire dp_cmd_t          cmd_i,
  output dp_stat_t              stat_o,
  output logic                  running_valid_o,
  output logic [IDX_W-1:0]      running_index_o,
  output logic                  released_valid_o,
  output logic [IDX_W-1:0]      released_index_o,
  output logic [CNT_W-1:0]      released_count_o,
  output logic                  queue_full_o
);

  localparam int TW = $clog2(NUM_TASKS);
  localparam int CW = $clog2(NUM_TASKS + 1);
  localparam logic [TW-1:0] LAST = TW'(NUM_TASKS - 1);
  localparam logic [CW-1:0] DEPTH = CW'(NUM_TASKS);

  typedef struct packed {
    logic [PC_W-1:0] pc;
    logic            dev;
    logic [OP_W-1:0] op;
  } ctx_t;

  function automatic logic [TW-1:0] wrap_inc(input logic [TW-1:0] x);
    return (x == LAST) ? '0 : x + 1'b1;
  endfunction

  // latched beat
  cmd_e             cmd_q;
  logic [IDX_W-1:0] task_q;
  logic             dev_q;
  logic [OP_W-1:0]  op_q;
  logic [PC_W-1:0]  pc_q;

  // scheduler state
  logic [NUM_TASKS-1:0] ready_q;
  logic                 cur_valid_q;
  logic [TW-1:0]        cur_q;
  logic [TW-1:0]        cand_q;
  logic [CW-1:0]        steps_q;

  // device queues, index 0 is device 1
  logic [TW-1:0]        head_q [2];
  logic [TW-1:0]        tail_q [2];
  logic [CW-1:0]        fill_q [2];
  logic [TW-1:0]        fifo1_mem [NUM_TASKS];
  logic [TW-1:0]        fifo2_mem [NUM_TASKS];
  logic [TW-1:0]        fifo_rd_q;

  // access counts, an entry never written reads as zero
  logic [CNT_W-1:0]     uses1_mem [NUM_TASKS];
  logic [CNT_W-1:0]     uses2_mem [NUM_TASKS];
  logic [NUM_TASKS-1:0] uses_vld_q [2];
  logic [CNT_W-1:0]     uses_rd_q;
  logic                 uses_hit_q;

  ctx_t                 ctx_mem [NUM_TASKS];

  logic                 rel_q;
  logic [TW-1:0]        rel_idx_q;
  logic [CNT_W-1:0]     rel_cnt_q;
  logic                 full_q;

  logic                 out_rv_q;
  logic [IDX_W-1:0]     out_ri_q;
  logic                 out_lv_q;
  logic [IDX_W-1:0]     out_li_q;
  logic [CNT_W-1:0]     out_lc_q;
  logic                 out_full_q;

  logic                 sel;
  logic                 task_ok;
  logic [TW-1:0]        task_sel;
  logic                 sel_full;
  logic [CNT_W-1:0]     cnt_cur;
  logic [CNT_W-1:0]     cnt_new;

  assign sel      = (cmd_q == CMD_SYSCALL) ? dev_q : (cmd_q == CMD_DONE2);
  assign task_ok  = int'(task_q) < NUM_TASKS;
  assign task_sel = TW'(task_q);
  assign sel_full = (fill_q[sel] == DEPTH);
  assign cnt_cur  = uses_hit_q ? uses_rd_q : '0;
  assign cnt_new  = (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;

  assign stat_o.cmd        = cmd_q;
  assign stat_o.tick_go    = cur_valid_q && !ready_q[cur_q];
  assign stat_o.fifo_empty = (fill_q[sel] == '0);
  assign stat_o.sys_ok     = task_ok;
  assign stat_o.found      = ready_q[cand_q];
  assign stat_o.last       = (steps_q == CW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= cmd_e'(command_i);
      task_q <= task_index_i;
      dev_q  <= device_select_i;
      op_q   <= operation_i;
      pc_q   <= program_counter_i;
    end
  end

  // queue and context memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.sys_start) begin
      ctx_mem[task_sel] <= '{pc: pc_q, dev: dev_q, op: op_q};
      if (!sel_full) begin
        if (dev_q) fifo2_mem[tail_q[1]] <= task_sel;
        else       fifo1_mem[tail_q[0]] <= task_sel;
      end
    end
    fifo_rd_q <= sel ? fifo2_mem[head_q[1]] : fifo1_mem[head_q[0]];
  end

  // count memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.uses_upd) begin
      if (sel) uses2_mem[fifo_rd_q] <= cnt_new;
      else     uses1_mem[fifo_rd_q] <= cnt_new;
    end
    uses_rd_q  <= sel ? uses2_mem[fifo_rd_q] : uses1_mem[fifo_rd_q];
    uses_hit_q <= uses_vld_q[sel][fifo_rd_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q     <= {{(NUM_TASKS-1){1'b1}}, 1'b0};
      cur_valid_q <= 1'b1;
      cur_q       <= '0;
      cand_q      <= '0;
      steps_q     <= '0;
      head_q      <= '{default: '0};
      tail_q      <= '{default: '0};
      fill_q      <= '{default: '0};
      uses_vld_q  <= '{default: '0};
      rel_q       <= 1'b0;
      rel_idx_q   <= '0;
      rel_cnt_q   <= '0;
      full_q      <= 1'b0;
      out_rv_q    <= 1'b0;
      out_ri_q    <= '0;
      out_lv_q    <= 1'b0;
      out_li_q    <= '0;
      out_lc_q    <= '0;
      out_full_q  <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        rel_q     <= 1'b0;
        rel_idx_q <= '0;
        rel_cnt_q <= '0;
        full_q    <= 1'b0;
      end
      if (cmd_i.tick_start) begin
        // current task goes back to ready and is tried last
        ready_q[cur_q] <= 1'b1;
        cand_q         <= wrap_inc(cur_q);
        steps_q        <= DEPTH;
      end
      if (cmd_i.sys_start) begin
        ready_q[task_sel] <= 1'b0;
        if (sel_full) begin
          full_q <= 1'b1;
        end else begin
          tail_q[sel] <= wrap_inc(tail_q[sel]);
          fill_q[sel] <= fill_q[sel] + 1'b1;
        end
        cand_q  <= wrap_inc(cur_valid_q ? cur_q : LAST);
        steps_q <= DEPTH;
      end
      if (cmd_i.search) begin
        if (ready_q[cand_q]) begin
          cur_q           <= cand_q;
          cur_valid_q     <= 1'b1;
          ready_q[cand_q] <= 1'b0;
        end else if (steps_q == CW'(1)) begin
          cur_q       <= '0;
          cur_valid_q <= 1'b0;
        end else begin
          cand_q  <= wrap_inc(cand_q);
          steps_q <= steps_q - 1'b1;
        end
      end
      if (cmd_i.uses_upd) begin
        ready_q[fifo_rd_q]         <= 1'b1;
        uses_vld_q[sel][fifo_rd_q] <= 1'b1;
        head_q[sel] <= wrap_inc(head_q[sel]);
        fill_q[sel] <= fill_q[sel] - 1'b1;
        rel_q       <= 1'b1;
        rel_idx_q   <= fifo_rd_q;
        rel_cnt_q   <= cnt_new;
      end
      if (cmd_i.out_load) begin
        out_rv_q   <= cur_valid_q;
        out_ri_q   <= IDX_W'(cur_q);
        out_lv_q   <= rel_q;
        out_li_q   <= IDX_W'(rel_idx_q);
        out_lc_q   <= rel_cnt_q;
        out_full_q <= full_q;
      end
    end
  end

  assign running_valid_o  = out_rv_q;
  assign running_index_o  = out_ri_q;
  assign released_valid_o = out_lv_q;
  assign released_index_o = out_li_q;
  assign released_count_o = out_lc_q;
  assign queue_full_o     = out_full_q;

endmodule

`default_nettype wire

@@ src/round_robin_scheduler_io_queues_core.sv @@
// top level of the round-robin scheduler with two device wait queues
//
//   channel | direction | fields
//   --------+-----------+-------------------------------------------------------------
//   in      | input     | command, task_index, device_select, operation, program_counter
//   out     | output    | running_valid/index, released_valid/index/count, queue_full
//
// one beat at a time: a completion on a non-empty queue runs from accept to result through
// the fifo head read, the count read and the update; a tick or syscall that runs the ready
// search visits k candidates (1 to NUM_TASKS), one a cycle; an idle tick, an empty-queue
// completion or an ignored syscall goes straight from the exec state to the result.
// a finished result waits in the output register while the next beat is accepted.
// reset puts task 0 running, the rest ready, both queues empty, all counts zero.
`default_nettype none

module round_robin_scheduler_io_queues_core import rrs_pkg::*; #(
  parameter int NUM_TASKS = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       command_i,
  input  wire logic [IDX_W-1:0] task_index_i,
  input  wire logic             device_select_i,
  input  wire logic [OP_W-1:0]  operation_i,
  input  wire logic [PC_W-1:0]  program_counter_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  running_valid_o,
  output logic [IDX_W-1:0]      running_index_o,
  output logic                  released_valid_o,
  output logic [IDX_W-1:0]      released_index_o,
  output logic [CNT_W-1:0]      released_count_o,
  output logic                  queue_full_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  rrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  rrs_dp #(
    .NUM_TASKS (NUM_TASKS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .command_i         (command_i),
    .task_index_i      (task_index_i),
    .device_select_i   (device_select_i),
    .operation_i       (operation_i),
    .program_counter_i (program_counter_i),
    .cmd_i             (dp_cmd),
    .stat_o            (dp_stat),
    .running_valid_o   (running_valid_o),
    .running_index_o   (running_index_o),
    .released_valid_o  (released_valid_o),
    .released_index_o  (released_index_o),
    .released_count_o  (released_count_o),
    .queue_full_o      (queue_full_o)
  );

endmodule

`default_nettype wire
